// ===== rtl/core/windowed_count_sketch_assert.svh =====
// Assertion macros used by the port-level checker of the windowed count sketch.
// Holds only macro definitions; no dependencies.
`ifndef WINDOWED_COUNT_SKETCH_ASSERT_SVH
`define WINDOWED_COUNT_SKETCH_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WCS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define WCS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/wcs_pkg.sv =====
// Shared types and constants of the windowed count sketch.
// No dependencies.
package wcs_pkg;

  localparam int unsigned ColW    = 10;
  localparam int unsigned EstW    = 28;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned CtrW    = 16;
  localparam int unsigned TagW    = 16;

  // Sketch geometry. The datapath keeps four column and sign inputs and
  // takes the area from the low bits of the epoch, so these stay fixed.
  localparam int unsigned ROWS    = 4;
  localparam int unsigned COLUMNS = 1024;
  localparam int unsigned AREAS   = 4;

  // Function codes of the input item.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_SCALE  = 1'b1;

  // Counter thresholds of the linear range.
  localparam logic signed [CtrW-1:0] LinMax = 16'sd127;
  localparam logic signed [CtrW-1:0] LinMin = -16'sd128;

  // Divider request and response.
  typedef struct packed {
    logic          start;
    logic [SeqW-1:0] dividend;
    logic [15:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [SeqW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/wcs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/wcs_div.sv =====
// Restoring bit-serial divider: 32-bit dividend by 16-bit divisor.
// Depends on wcs_pkg.
module wcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wcs_pkg::div_req_t req_i,
  output wcs_pkg::div_rsp_t rsp_o
);
  import wcs_pkg::*;

  logic [SeqW-1:0] quo_q, quo_d;
  logic [16:0]     rem_q, rem_d;
  logic [15:0]     dvs_q, dvs_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [16:0]     trial;

  // One quotient bit per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], quo_q[SeqW-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = (req_i.divisor == 16'd0) ? 16'd1 : req_i.divisor;
      cnt_d  = 6'(SeqW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[SeqW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SeqW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/windowed_count_sketch.sv =====
// Windowed count sketch: one input and one output transfer per item.
//
// Input channel: in_valid_i / in_stall_o with the item fields. Output
// channel: out_valid_o / out_stall_i with estimate_o and item_count_o.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; write only while the block is idle.
//
// One item is worked at a time. The epoch comes from a serial divider.
// An insert then reads and writes back one counter per row in the counter
// RAM (S_RD, S_WR); a query reads ROWS*AREAS counters (S_QRD, S_QACC) and
// sorts the row sums over ROWS+1 passes. An insert that enters a new epoch
// clears that area's ROWS*COLUMNS counters (4096 by default) first.
//
// After reset the block sweeps the whole counter RAM, all AREAS*ROWS*COLUMNS
// counters (16384 by default), before taking its first item. A stalled
// result stays in the output register; the next item is taken only after
// the result has been transferred.
module windowed_count_sketch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [9:0]                    column_row0_i,
  input  logic [9:0]                    column_row1_i,
  input  logic [9:0]                    column_row2_i,
  input  logic [9:0]                    column_row3_i,
  input  logic                          sign_row0_i,
  input  logic                          sign_row1_i,
  input  logic                          sign_row2_i,
  input  logic                          sign_row3_i,
  input  logic [15:0]                   random_draw_i,
  input  logic [2:0]                    lookback_epochs_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [27:0]            estimate_o,
  output logic [31:0]                   item_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import wcs_pkg::*;

  localparam int unsigned ColAW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RowAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AreaAW = $clog2(AREAS);
  localparam int unsigned Depth  = AREAS * ROWS * COLUMNS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned AreaSz = ROWS * COLUMNS;
  localparam int unsigned AreaSzW = $clog2(AreaSz);
  localparam int unsigned SumW   = 48;

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DIV    = 11'b00000000100,
    S_CLEAR  = 11'b00000001000,
    S_RD     = 11'b00000010000,
    S_WR     = 11'b00000100000,
    S_QRD    = 11'b00001000000,
    S_QACC   = 11'b00010000000,
    S_SORT   = 11'b00100000000,
    S_MED    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] window_q;
  logic [3:0]  scale_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_o && !in_valid_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 16'd1024;
      scale_q  <= 4'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW: window_q <= cfg_data_i;
        CFG_SCALE:  scale_q  <= cfg_data_i[3:0];
        default:    ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]       func_q;
  logic [ColW-1:0]  col_q [4];
  logic [3:0]       sgn_q;
  logic [15:0]      draw_q;
  logic [2:0]       look_q;

  logic [SeqW-1:0]  seq_q, seq_d;
  logic [TagW-1:0]  tag_q [AREAS];
  logic [SeqW-1:0]  epoch_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [RowAW-1:0] row_q, row_d;
  logic [AreaAW-1:0] ar_q, ar_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] vals_q [ROWS];
  logic [RowAW:0]   pass_q, pass_d;
  logic             odd_q, odd_d;
  logic             out_valid_q;
  logic signed [EstW-1:0] est_q;
  logic [SeqW-1:0]  cnt_out_q;

  div_req_t dreq;
  div_rsp_t drsp;
  wcs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [CtrW-1:0]  wdata, rdata;
  wcs_ram #(.Width(CtrW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic accept;
  assign in_stall_o = !((state_q == S_IDLE) && !out_valid_q);
  assign accept     = in_valid_i && !in_stall_o;

  // Column and sign of the current row.
  logic [ColAW-1:0]  row_col;
  logic              row_sgn;
  always_comb begin
    row_col = ColAW'(col_q[row_q[1:0]] % COLUMNS);
    row_sgn = sgn_q[row_q[1:0]];
  end

  logic [AddrW-1:0] row_addr;
  assign row_addr = AddrW'(ar_q) * AddrW'(AreaSz) + AddrW'(row_q) * AddrW'(COLUMNS)
                  + AddrW'(row_col);

  // Insert update of one counter.
  logic signed [CtrW-1:0] c;
  logic lucky, inner, step_ok;
  logic signed [CtrW-1:0] c_new;
  always_comb begin
    c = signed'(rdata);
    lucky = (scale_q == 4'd0) || ((draw_q >> (5'd16 - {1'b0, scale_q})) == 16'd0);
    inner = (c < LinMax && c > LinMin) || (c == LinMax && !row_sgn) ||
            (c == LinMin && row_sgn);
    step_ok = row_sgn ? (c != 16'sh7fff) : (c != -16'sh8000);
    c_new = row_sgn ? c + 16'sd1 : c - 16'sd1;
  end

  // Decode of one counter.
  logic signed [SumW-1:0] dec;
  always_comb begin
    if (c > LinMax) begin
      dec = 48'sd127 + ((SumW'(c) - 48'sd127) <<< scale_q);
    end else if (c < LinMin) begin
      dec = -48'sd128 + ((SumW'(c) + 48'sd128) <<< scale_q);
    end else begin
      dec = SumW'(c);
    end
  end

  // Area inclusion test for a query.
  logic signed [SeqW+1:0] floor_ep;
  logic incl;
  assign floor_ep = signed'({2'b00, epoch_q}) - signed'((SeqW+2)'(look_q));
  assign incl = signed'((SeqW+2)'(tag_q[ar_q])) >= floor_ep;

  // Median of the sorted values.
  logic signed [SumW:0] msum;
  logic signed [SumW-1:0] med;
  always_comb begin
    if ((ROWS % 2) != 0) begin
      msum = (SumW+1)'(vals_q[(ROWS-1)/2]);
      med  = vals_q[(ROWS-1)/2];
    end else begin
      msum = (SumW+1)'(vals_q[ROWS/2-1]) + (SumW+1)'(vals_q[ROWS/2]);
      med  = SumW'(msum / 2);
    end
  end

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    seq_d   = seq_q;
    ptr_d   = ptr_q;
    row_d   = row_q;
    ar_d    = ar_q;
    sum_d   = sum_q;
    pass_d  = pass_q;
    odd_d   = odd_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = '0;
    raddr   = row_addr;
    dreq.start    = 1'b0;
    dreq.dividend = seq_q;
    dreq.divisor  = window_q;
    case (state_q)
      S_INIT: begin
        we = 1'b1;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_q == AddrW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_INSERT, FUNC_QUERY: begin
              dreq.start = 1'b1;
              state_d = S_DIV;
            end
            FUNC_CLEAR: begin
              seq_d = '0;
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        row_d = '0;
        ar_d  = '0;
        sum_d = '0;
        if (drsp.done) begin
          if (func_q == FUNC_INSERT) begin
            ar_d = drsp.quotient[AreaAW-1:0];
            if (tag_q[drsp.quotient[AreaAW-1:0]] != drsp.quotient[TagW-1:0]) begin
              ptr_d = AddrW'(drsp.quotient[AreaAW-1:0]) * AddrW'(AreaSz);
              state_d = S_CLEAR;
            end else begin
              state_d = S_RD;
            end
          end else begin
            state_d = S_QRD;
          end
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_q[AreaSzW-1:0] == AreaSzW'(AreaSz - 1)) state_d = S_RD;
      end
      S_RD: state_d = S_WR;
      S_WR: begin
        waddr = row_addr;
        wdata = c_new;
        we    = (inner || lucky) && step_ok;
        if (row_q == RowAW'(ROWS - 1)) begin
          seq_d = seq_q + 32'd1;
          state_d = S_OUT;
        end else begin
          row_d = row_q + RowAW'(1);
          state_d = S_RD;
        end
      end
      S_QRD: state_d = S_QACC;
      S_QACC: begin
        if (incl) sum_d = sum_q + dec;
        if (ar_q == AreaAW'(AREAS - 1)) begin
          ar_d = '0;
          sum_d = '0;
          if (row_q == RowAW'(ROWS - 1)) begin
            pass_d = '0;
            odd_d  = 1'b0;
            state_d = S_SORT;
          end else begin
            row_d = row_q + RowAW'(1);
            state_d = S_QRD;
          end
        end else begin
          ar_d = ar_q + AreaAW'(1);
          state_d = S_QRD;
        end
      end
      S_SORT: begin
        odd_d = !odd_q;
        pass_d = pass_q + (RowAW+1)'(1);
        if (pass_q == (RowAW+1)'(ROWS)) state_d = S_MED;
      end
      S_MED: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Row sum before the row sign is applied, for the last area of a row.
  logic signed [SumW-1:0] row_total;
  assign row_total = (incl ? sum_q + dec : sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      seq_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AREAS; a++) tag_q[a] <= '0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      ptr_q   <= ptr_d;
      if (state_q == S_DIV && drsp.done && func_q == FUNC_INSERT) begin
        tag_q[drsp.quotient[AreaAW-1:0]] <= drsp.quotient[TagW-1:0];
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end else if (state_q == S_IDLE && accept && func_i != FUNC_INSERT
                   && func_i != FUNC_QUERY) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == S_WR && row_q == RowAW'(ROWS - 1)) || state_q == S_MED) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    ar_q   <= ar_d;
    sum_q  <= sum_d;
    pass_q <= pass_d;
    odd_q  <= odd_d;
    if (accept) begin
      func_q    <= func_i;
      col_q[0]  <= column_row0_i;
      col_q[1]  <= column_row1_i;
      col_q[2]  <= column_row2_i;
      col_q[3]  <= column_row3_i;
      sgn_q     <= {sign_row3_i, sign_row2_i, sign_row1_i, sign_row0_i};
      draw_q    <= random_draw_i;
      look_q    <= lookback_epochs_i;
      est_q     <= '0;
      cnt_out_q <= (func_i == FUNC_CLEAR) ? '0 : seq_q;
    end
    if (state_q == S_DIV && drsp.done) epoch_q <= drsp.quotient;
    if (state_q == S_QACC && ar_q == AreaAW'(AREAS - 1)) begin
      vals_q[row_q] <= row_sgn ? row_total : -row_total;
    end
    // Odd-even transposition sort, one pass per cycle.
    if (state_q == S_SORT) begin
      for (int i = 0; i + 1 < ROWS; i++) begin
        if ((i % 2) == (odd_q ? 1 : 0) && vals_q[i] > vals_q[i+1]) begin
          vals_q[i]   <= vals_q[i+1];
          vals_q[i+1] <= vals_q[i];
        end
      end
    end
    if (state_q == S_WR && row_q == RowAW'(ROWS - 1)) cnt_out_q <= seq_q + 32'd1;
    if (state_q == S_MED) begin
      if (med > 48'sd134217727) est_q <= 28'sh7ffffff;
      else if (med < -48'sd134217728) est_q <= -28'sh8000000;
      else est_q <= EstW'(med);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign estimate_o   = est_q;
  assign item_count_o = cnt_out_q;

endmodule

// ===== rtl/core/wcs_checker.sv =====
// Port-level checker for the windowed count sketch, bound to the top level.
// Depends on windowed_count_sketch_assert.svh.
`include "windowed_count_sketch_assert.svh"
module wcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [27:0] estimate_o,
  input logic [31:0] item_count_o,
  input logic        cfg_ready_o
);

  // A held result keeps its payload.
  `WCS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(item_count_o) && $stable(estimate_o))
  // No input transfer while a result waits.
  `WCS_ASSERT_IMP(a_one, clk_i, rst_ni, out_valid_o, in_stall_o)
  // An accepted item keeps the input side closed next cycle.
  `WCS_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // Configuration only while idle.
  `WCS_ASSERT_IMP(a_cfg, clk_i, rst_ni, cfg_ready_o, !out_valid_o)

endmodule

bind windowed_count_sketch wcs_checker u_wcs_checker (.*);

// ===== tb/sv/windowed_count_sketch_checker.sv =====
// Checker of the windowed count sketch: watches the item, result and register channels,
// predicts each result and compares it. Depends on wcs_pkg.
`timescale 1ns / 100ps
module windowed_count_sketch_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         func_i,
  input  logic [39:0]        columns_i,
  input  logic [3:0]         signs_i,
  input  logic [15:0]        random_draw_i,
  input  logic [2:0]         lookback_epochs_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [27:0] estimate_i,
  input  logic [31:0]        item_count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import wcs_pkg::*;

  typedef struct packed {
    logic signed [27:0] estimate;
    logic [31:0]        item_count;
  } sketch_result_t;

  // Mirror of the block state.
  logic signed [15:0] ctr_mem [0:16383];
  logic [15:0]        area_tag [0:3];
  logic [31:0]        seq_cnt;
  logic [15:0]        window_len;
  logic [3:0]         scale_sh;
  sketch_result_t     expected_results [$];

  assign pending_o = expected_results.size();

  function automatic longint decode_ctr(logic signed [15:0] c);
    longint v;
    v = longint'(c);
    if (v > 127) return 127 + (v - 127) * (longint'(1) << scale_sh);
    if (v < -128) return -128 + (v + 128) * (longint'(1) << scale_sh);
    return v;
  endfunction

  // Works out one item's result and updates the mirrored state.
  function automatic sketch_result_t sketch_predict(logic [1:0] fn, logic [39:0] cols,
                                                    logic [3:0] sg, logic [15:0] draw,
                                                    logic [2:0] lb);
    sketch_result_t res;
    logic [31:0] div;
    logic [15:0] ep;
    int unsigned area;
    int unsigned p;
    bit lucky;
    bit inner;
    int c;
    int s;
    int n;
    longint vals [4];
    longint cur;
    longint floor_ep;
    longint sum;
    longint t;
    longint m;
    div = (window_len == 0) ? 32'd1 : 32'(window_len);
    res.estimate = '0;
    case (func_e'(fn))
      FUNC_INSERT: begin
        ep = 16'(seq_cnt / div);
        area = ep % 4;
        lucky = (scale_sh == 0) || ((draw >> (16 - scale_sh)) == 0);
        if (area_tag[area] != ep) begin
          area_tag[area] = ep;
          for (int i = 0; i < 4096; i++) ctr_mem[area * 4096 + i] = '0;
        end
        for (int r = 0; r < 4; r++) begin
          p = area * 4096 + r * 1024 + cols[r*10 +: 10];
          s = sg[r] ? 1 : -1;
          c = int'(ctr_mem[p]);
          inner = (c < 127 && c > -128) || (c == 127 && s < 0) || (c == -128 && s > 0);
          if (inner || lucky) begin
            n = c + s;
            if (n <= 32767 && n >= -32768) ctr_mem[p] = 16'(n);
          end
        end
        seq_cnt = seq_cnt + 1;
      end
      FUNC_QUERY: begin
        cur = longint'(seq_cnt / div);
        floor_ep = cur - longint'(lb);
        for (int r = 0; r < 4; r++) begin
          sum = 0;
          for (int a = 0; a < 4; a++) begin
            if (longint'(area_tag[a]) >= floor_ep)
              sum += decode_ctr(ctr_mem[a * 4096 + r * 1024 + cols[r*10 +: 10]]);
          end
          vals[r] = sg[r] ? sum : -sum;
        end
        // Sort the row sums and average the two middle ones.
        for (int i = 1; i < 4; i++) begin
          for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
            t = vals[j];
            vals[j] = vals[j-1];
            vals[j-1] = t;
          end
        end
        m = (vals[1] + vals[2]) / 2;
        if (m > 134217727) m = 134217727;
        if (m < -134217728) m = -134217728;
        res.estimate = 28'(m);
      end
      FUNC_CLEAR: seq_cnt = '0;
      default: ;
    endcase
    res.item_count = seq_cnt;
    return res;
  endfunction

  // Compare result transfers, then account for register writes and item transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    sketch_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < 16384; i++) ctr_mem[i] = '0;
      for (int a = 0; a < 4; a++) area_tag[a] = '0;
      seq_cnt = '0;
      window_len = 16'd1024;
      scale_sh = 4'd8;
      errors_o = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          errors_o++;
        end else begin
          exp_res = expected_results.pop_front();
          if (estimate_i !== exp_res.estimate) begin
            $error("estimate: expected %0d, got %0d", exp_res.estimate, estimate_i);
            errors_o++;
          end
          if (item_count_i !== exp_res.item_count) begin
            $error("item_count: expected %0d, got %0d", exp_res.item_count, item_count_i);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WINDOW) window_len = cfg_data_i;
        else scale_sh = cfg_data_i[3:0];
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(sketch_predict(func_i, columns_i, signs_i,
                                                  random_draw_i, lookback_epochs_i));
    end
  end

endmodule

// ===== tb/sv/windowed_count_sketch_tb.sv =====
// Top of the windowed count sketch testbench: clock, reset, stimulus and verdict.
// Depends on wcs_pkg, windowed_count_sketch and windowed_count_sketch_checker.
`timescale 1ns / 100ps
module windowed_count_sketch_tb;
  import wcs_pkg::*;

  localparam int unsigned WatchdogLimit = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  func_e              func = FUNC_INSERT;
  logic [39:0]        columns = '0;
  logic [3:0]         signs = '0;
  logic [15:0]        random_draw = '0;
  logic [2:0]         lookback = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [27:0] estimate;
  logic [31:0]        item_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_WINDOW;
  logic [15:0]        cfg_data = '0;
  int                 errors;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int unsigned        quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  windowed_count_sketch i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .column_row0_i(columns[9:0]), .column_row1_i(columns[19:10]),
    .column_row2_i(columns[29:20]), .column_row3_i(columns[39:30]),
    .sign_row0_i(signs[0]), .sign_row1_i(signs[1]),
    .sign_row2_i(signs[2]), .sign_row3_i(signs[3]),
    .random_draw_i(random_draw), .lookback_epochs_i(lookback),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .estimate_o(estimate), .item_count_o(item_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  windowed_count_sketch_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .func_i(func),
    .columns_i(columns), .signs_i(signs), .random_draw_i(random_draw),
    .lookback_epochs_i(lookback),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .estimate_i(estimate), .item_count_i(item_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // The result side stalls at random.
  always @(negedge clk_i) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Presents one item and waits for its transfer; starts and ends at a falling edge.
  task automatic send_item(func_e f, logic [39:0] cols, logic [3:0] sg,
                           logic [15:0] draw, logic [2:0] lb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    func = f;
    columns = cols;
    signs = sg;
    random_draw = draw;
    lookback = lb;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Waits for all results, then writes both registers.
  task automatic set_registers(logic [15:0] window_len, logic [3:0] scale_sh);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    for (int i = 0; i < 2; i++) begin
      cfg_valid = 1'b1;
      cfg_index = (i == 0) ? CFG_WINDOW : CFG_SCALE;
      cfg_data = (i == 0) ? window_len : 16'(scale_sh);
      do @(posedge clk_i); while (!cfg_ready);
      @(negedge clk_i);
    end
    cfg_valid = 1'b0;
  endtask

  // Random item; most traffic hits a few hot columns with a fixed sign so that
  // counters climb past the linear range.
  task automatic send_random_item();
    logic [39:0] cols;
    logic [3:0] sg;
    logic [15:0] draw;
    int unsigned pick;
    bit hot;
    func_e f;
    pick = $urandom_range(99);
    if (pick < 62) f = FUNC_INSERT;
    else if (pick < 92) f = FUNC_QUERY;
    else if (pick < 96) f = FUNC_CLEAR;
    else f = FUNC_NONE;
    hot = ($urandom_range(99) < 70);
    for (int r = 0; r < 4; r++) begin
      cols[r*10 +: 10] = hot ? 10'($urandom_range(3)) : 10'($urandom);
      sg[r] = hot ? ~cols[r*10] : 1'($urandom);
    end
    if (hot && $urandom_range(9) == 0) sg = 4'($urandom);
    draw = ($urandom_range(2) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
    send_item(f, cols, sg, draw, 3'($urandom));
  endtask

  initial begin
    int unsigned phase_items [8] = '{60, 12, 364, 8, 150, 300, 300, 200};
    logic [15:0] phase_window [8] = '{16'd40, 16'd1, 16'd2000, 16'd0, 16'd16,
                                      16'd65535, 16'd100, 16'd300};
    logic [3:0]  phase_scale [8] = '{4'd3, 4'd15, 4'd1, 4'd4, 4'd0, 4'd15, 4'd2, 4'd6};
    int          idle_modes [4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{38, 38}};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset settings.
    send_item(FUNC_QUERY, '0, 4'hF, 16'h0000, 3'd0);
    send_item(FUNC_INSERT, '0, 4'hF, 16'h0000, 3'd0);
    send_item(FUNC_INSERT, {4{10'd1023}}, 4'h0, 16'hFFFF, 3'd7);
    send_item(FUNC_INSERT, {10'd1023, 10'd0, 10'd1023, 10'd0}, 4'b0101, 16'h00FF, 3'd0);
    send_item(FUNC_QUERY, '0, 4'hF, 16'hFFFF, 3'd0);
    send_item(FUNC_QUERY, {4{10'd1023}}, 4'h0, 16'h0000, 3'd7);
    send_item(FUNC_QUERY, {10'd1023, 10'd0, 10'd1023, 10'd0}, 4'b1010, 16'h1234, 3'd3);
    send_item(FUNC_NONE, {4{10'h2AA}}, 4'hA, 16'hAAAA, 3'd5);
    send_item(FUNC_CLEAR, {4{10'h155}}, 4'h5, 16'h5555, 3'd2);
    send_item(FUNC_QUERY, '0, 4'hF, 16'h0000, 3'd7);
    // Drive one counter per row well past the linear range with every draw lucky.
    set_registers(16'd65535, 4'd0);
    for (int i = 0; i < 140; i++)
      send_item(FUNC_INSERT, {4{10'd5}}, 4'hF, 16'($urandom), 3'd0);
    send_item(FUNC_QUERY, {4{10'd5}}, 4'hF, 16'h0000, 3'd0);
    send_item(FUNC_INSERT, {4{10'd5}}, 4'h0, 16'hFFFF, 3'd0);
    set_registers(16'd65535, 4'd15);
    send_item(FUNC_INSERT, {4{10'd5}}, 4'hF, 16'hFFFF, 3'd0);
    send_item(FUNC_INSERT, {4{10'd5}}, 4'hF, 16'h0001, 3'd0);
    send_item(FUNC_QUERY, {4{10'd5}}, 4'hF, 16'h0000, 3'd7);
    send_item(FUNC_QUERY, {4{10'd5}}, 4'h0, 16'h0000, 3'd7);

    // Random phases over several register settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_registers(phase_window[ph], phase_scale[ph]);
      send_idle_pct = idle_modes[ph % 4][0];
      stall_pct = idle_modes[ph % 4][1];
      for (int i = 0; i < phase_items[ph]; i++) send_random_item();
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk_i);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
